// ----- hw/rtl/gsr_pkg.sv -----
// Shared types, command codes and frame helpers for the game-pad serial responder.
`timescale 1ns / 1ps
`default_nettype none

package gsr_pkg;

   // Bus and frame bytes.
   localparam logic [7:0] OPEN_BUS    = 8'hFF;
   localparam logic [7:0] START_BYTE  = 8'h01;
   localparam logic [7:0] STATUS_BYTE = 8'h5A;

   // Command bytes.
   localparam logic [7:0] CMD_POLL       = 8'h42;
   localparam logic [7:0] CMD_CONFIG     = 8'h43;
   localparam logic [7:0] CMD_SET_ANALOG = 8'h44;
   localparam logic [7:0] CMD_GET_ANALOG = 8'h45;
   localparam logic [7:0] CMD_QUERY_46   = 8'h46;
   localparam logic [7:0] CMD_QUERY_47   = 8'h47;
   localparam logic [7:0] CMD_QUERY_4C   = 8'h4C;
   localparam logic [7:0] CMD_RUMBLE     = 8'h4D;

   // Argument bytes of the configuration commands.
   localparam logic [7:0] ARG_OFF  = 8'h00;
   localparam logic [7:0] ARG_ON   = 8'h01;
   localparam logic [7:0] LOCK_OFF = 8'h02;
   localparam logic [7:0] LOCK_ON  = 8'h03;

   // Mode nibble and payload length (in halfwords) of the id byte.
   localparam logic [3:0] MODE_CONFIG  = 4'hF;
   localparam logic [3:0] MODE_ANALOG  = 4'h7;
   localparam logic [3:0] MODE_DIGITAL = 4'h4;
   localparam logic [3:0] WORDS_LONG   = 4'h3;
   localparam logic [3:0] WORDS_SHORT  = 4'h1;

   // Frame geometry and the steps at which commands look at the host byte.
   localparam int FRAME_BYTES       = 8;
   localparam int FRAME_SHORT       = 4;
   localparam int ARG_STEP          = 2;
   localparam int LOCK_STEP         = 3;
   localparam int RUMBLE_FIRST_STEP = 2;
   localparam int RUMBLE_LAST_STEP  = 6;

   typedef enum logic [9:0] {
      ST_IDLE   = 10'b00_0000_0001,
      ST_READY  = 10'b00_0000_0010,
      ST_POLL   = 10'b00_0000_0100,
      ST_CFG    = 10'b00_0000_1000,
      ST_SETANA = 10'b00_0001_0000,
      ST_GETANA = 10'b00_0010_0000,
      ST_Q46    = 10'b00_0100_0000,
      ST_Q47    = 10'b00_1000_0000,
      ST_Q4C    = 10'b01_0000_0000,
      ST_RUMBLE = 10'b10_0000_0000
   } cmd_state_type;

   typedef logic [FRAME_BYTES-1:0][7:0] frame_type;

   typedef struct packed {
      logic        kind;
      logic [7:0]  host_byte;
      logic [15:0] buttons;
      logic [7:0]  left_x;
      logic [7:0]  left_y;
      logic [7:0]  right_x;
      logic [7:0]  right_y;
   } item_type;

   typedef struct packed {
      logic [7:0]  reply_byte;
      logic        acknowledge;
      logic        invalid_sequence;
      logic        saw_ident;
      logic        saw_poll;
      logic        button_pressed_seen;
      logic        poll_done;
      logic [15:0] polled_button_bits;
   } result_type;

   // Id byte: mode in the high nibble, payload halfwords in the low nibble.
   function automatic logic [7:0] ident_byte(input logic config_on, input logic analog_on);
      logic [3:0] mode;
      logic [3:0] words;
      mode  = config_on ? MODE_CONFIG : (analog_on ? MODE_ANALOG : MODE_DIGITAL);
      words = (config_on || analog_on) ? WORDS_LONG : WORDS_SHORT;
      return {mode, words};
   endfunction

   function automatic frame_type make_frame(input logic [7:0] ident,
                                            input logic [7:0] b2, input logic [7:0] b3,
                                            input logic [7:0] b4, input logic [7:0] b5,
                                            input logic [7:0] b6, input logic [7:0] b7);
      frame_type f;
      f    = '0;
      f[0] = ident;
      f[1] = STATUS_BYTE;
      f[2] = b2;
      f[3] = b3;
      f[4] = b4;
      f[5] = b5;
      f[6] = b6;
      f[7] = b7;
      return f;
   endfunction

endpackage

`default_nettype wire

// ----- hw/rtl/gsr_ingress.sv -----
// Input register stage that holds one host transaction until the engine takes it.
`timescale 1ns / 1ps
`default_nettype none

module gsr_ingress (
   input  wire logic              clock,
   input  wire logic              reset,
   input  wire logic              req_valid,
   output logic                   req_stall,
   input  wire gsr_pkg::item_type req_item,
   input  wire logic              take,
   output logic                   item_valid,
   output gsr_pkg::item_type      item
);
   import gsr_pkg::*;

   logic     valid_ff;
   logic     valid_in;
   item_type item_ff;
   logic     accept;

   // The stage refills in the same cycle that its content moves on.
   assign req_stall = valid_ff && !take;
   assign accept    = req_valid && !req_stall;

   always_comb begin
      valid_in = valid_ff;
      if (accept) begin
         valid_in = 1'b1;
      end else if (take) begin
         valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else begin
         valid_ff <= valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (accept) begin
         item_ff <= req_item;
      end
   end

   assign item_valid = valid_ff;
   assign item       = item_ff;

endmodule

`default_nettype wire

// ----- hw/rtl/gsr_engine.sv -----
// Command state, frame stores and the single-pass per-byte decision logic.
`timescale 1ns / 1ps
`default_nettype none

module gsr_engine #(
   parameter int FRAME_DEPTH  = 8,
   parameter int RUMBLE_DEPTH = 6
) (
   input  wire logic              clock,
   input  wire logic              reset,
   input  wire logic              fire,
   input  wire gsr_pkg::item_type item,
   output gsr_pkg::result_type    result
);
   import gsr_pkg::*;

   localparam int STEP_W = $clog2(FRAME_DEPTH);
   localparam logic [STEP_W:0] DEPTH_LIMIT = (STEP_W + 1)'(FRAME_DEPTH);
   localparam logic [STEP_W:0] LEN_LONG    = (STEP_W + 1)'(FRAME_BYTES);
   localparam logic [STEP_W:0] LEN_SHORT   = (STEP_W + 1)'(FRAME_SHORT);

   cmd_state_type     state_ff, state_in;
   logic [STEP_W-1:0] step_ff, step_in;
   logic              long_ff, long_in;
   logic              arg_ff, arg_in;
   logic              analog_ff, analog_in;
   logic              config_ff, config_in;
   logic              lock_ff, lock_in;
   logic [7:0]        tx_ff [FRAME_DEPTH];
   logic [7:0]        tx_in [FRAME_DEPTH];
   logic [7:0]        rumble_ff [RUMBLE_DEPTH];
   logic [7:0]        rumble_in [RUMBLE_DEPTH];

   logic [7:0]        d;
   logic [7:0]        ident;
   logic [STEP_W:0]   step_inc;
   logic [STEP_W:0]   frame_len;
   logic              wrap;
   logic              overrun;
   logic [7:0]        tx_rd;
   logic              rumble_hit;
   logic [7:0]        rumble_rd;
   frame_type         poll_frame;
   frame_type         new_frame;
   logic              load;
   logic              end_xfer;
   logic              active;

   assign d         = item.host_byte;
   assign ident     = ident_byte(config_ff, analog_ff);
   assign step_inc  = {1'b0, step_ff} + (STEP_W + 1)'(1);
   assign frame_len = long_ff ? LEN_LONG : LEN_SHORT;
   assign wrap      = (step_inc == frame_len);
   assign overrun   = ({1'b0, step_ff} >= DEPTH_LIMIT);
   assign tx_rd     = tx_ff[step_ff];

   assign poll_frame = (analog_ff || config_ff)
      ? make_frame(ident, item.buttons[7:0], item.buttons[15:8],
                   item.right_x, item.right_y, item.left_x, item.left_y)
      : make_frame(ident, item.buttons[7:0], item.buttons[15:8],
                   8'h00, 8'h00, 8'h00, 8'h00);

   // Rumble slot that belongs to the current step, if any.
   always_comb begin
      rumble_hit = 1'b0;
      rumble_rd  = OPEN_BUS;
      for (int i = 0; i < RUMBLE_DEPTH; i++) begin
         if ((int'(step_ff) == i + RUMBLE_FIRST_STEP) &&
             (int'(step_ff) <= RUMBLE_LAST_STEP) && (int'(step_ff) < FRAME_DEPTH)) begin
            rumble_hit = 1'b1;
            rumble_rd  = rumble_ff[i];
         end
      end
   end

   always_comb begin
      state_in  = state_ff;
      step_in   = step_ff;
      long_in   = long_ff;
      arg_in    = arg_ff;
      analog_in = analog_ff;
      config_in = config_ff;
      lock_in   = lock_ff;
      tx_in     = tx_ff;
      rumble_in = rumble_ff;
      new_frame = '0;
      load      = 1'b0;
      end_xfer  = 1'b0;
      active    = 1'b0;
      result    = '0;
      result.reply_byte = OPEN_BUS;

      if (item.kind) begin
         end_xfer = 1'b1;
      end else begin
         // Only the host byte at the argument step is kept for later use.
         if (step_ff == STEP_W'(ARG_STEP)) begin
            arg_in = (d == ARG_ON);
         end

         unique case (state_ff)
            ST_IDLE: begin
               if (d == START_BYTE) begin
                  state_in = ST_READY;
                  result.acknowledge = 1'b1;
               end else if (d != OPEN_BUS) begin
                  result.invalid_sequence = 1'b1;
               end
            end
            ST_READY: begin
               step_in = '0;
               long_in = config_ff || analog_ff;
               load    = 1'b1;
               priority if (d == CMD_POLL) begin
                  state_in        = ST_POLL;
                  new_frame       = poll_frame;
                  result.saw_poll = 1'b1;
               end else if (d == CMD_CONFIG) begin
                  state_in  = ST_CFG;
                  new_frame = config_ff ? make_frame(ident, 8'h00, 8'h00, 8'h00, 8'h00,
                                                     8'h00, 8'h00)
                                        : poll_frame;
               end else if (config_ff && d == CMD_SET_ANALOG) begin
                  state_in  = ST_SETANA;
                  new_frame = make_frame(ident, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00);
                  rumble_in = '{default: OPEN_BUS};
               end else if (config_ff && d == CMD_GET_ANALOG) begin
                  state_in  = ST_GETANA;
                  new_frame = make_frame(ident, 8'h01, 8'h02, {7'h00, analog_ff},
                                         8'h02, 8'h01, 8'h00);
               end else if (config_ff && d == CMD_QUERY_46) begin
                  state_in  = ST_Q46;
                  new_frame = make_frame(ident, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00);
               end else if (config_ff && d == CMD_QUERY_47) begin
                  state_in  = ST_Q47;
                  new_frame = make_frame(ident, 8'h00, 8'h00, 8'h02, 8'h00, 8'h01, 8'h00);
               end else if (config_ff && d == CMD_QUERY_4C) begin
                  state_in  = ST_Q4C;
                  new_frame = make_frame(ident, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00);
               end else if (config_ff && d == CMD_RUMBLE) begin
                  state_in  = ST_RUMBLE;
                  new_frame = make_frame(ident, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00);
               end else begin
                  load = 1'b0;
                  if (d != OPEN_BUS) begin
                     result.invalid_sequence = 1'b1;
                  end
               end
               if (load) begin
                  // The first reply byte of the frame is the id byte.
                  result.saw_ident   = 1'b1;
                  result.reply_byte  = ident;
                  result.acknowledge = 1'b1;
                  step_in            = STEP_W'(1);
               end
            end
            default: begin
               active = 1'b1;
            end
         endcase

         if (load) begin
            for (int i = 0; i < FRAME_DEPTH; i++) begin
               tx_in[i] = '0;
            end
            for (int i = 0; i < FRAME_BYTES; i++) begin
               tx_in[i] = new_frame[i];
            end
         end

         if (active) begin
            // Side effects of the running command on this byte.
            unique case (state_ff)
               ST_CFG: begin
                  if (wrap) begin
                     config_in = arg_ff;
                  end
               end
               ST_SETANA: begin
                  if (step_ff == STEP_W'(ARG_STEP)) begin
                     if (d == ARG_OFF || d == ARG_ON) begin
                        analog_in = d[0];
                     end
                  end else if (step_ff == STEP_W'(LOCK_STEP)) begin
                     if (d == LOCK_OFF || d == LOCK_ON) begin
                        lock_in = d[0];
                     end
                  end
               end
               ST_Q46: begin
                  if (step_ff == STEP_W'(ARG_STEP)) begin
                     if (d == ARG_OFF) begin
                        tx_in[4] = 8'h01;
                        tx_in[5] = 8'h02;
                        tx_in[6] = 8'h00;
                        tx_in[7] = 8'h0A;
                     end else if (d == ARG_ON) begin
                        tx_in[4] = 8'h01;
                        tx_in[5] = 8'h01;
                        tx_in[6] = 8'h01;
                        tx_in[7] = 8'h14;
                     end
                  end
               end
               ST_Q47: begin
                  if (step_ff == STEP_W'(ARG_STEP) && d != ARG_OFF) begin
                     tx_in[4] = 8'h00;
                     tx_in[5] = 8'h00;
                     tx_in[6] = 8'h00;
                     tx_in[7] = 8'h00;
                  end
               end
               ST_Q4C: begin
                  if (step_ff == STEP_W'(ARG_STEP)) begin
                     if (d == ARG_OFF) begin
                        tx_in[5] = 8'h04;
                     end else if (d == ARG_ON) begin
                        tx_in[5] = 8'h07;
                     end
                  end
               end
               ST_RUMBLE: begin
                  // The old map entry goes out while the host byte replaces it.
                  for (int i = 0; i < RUMBLE_DEPTH; i++) begin
                     if ((int'(step_ff) == i + RUMBLE_FIRST_STEP) &&
                         (int'(step_ff) <= RUMBLE_LAST_STEP) &&
                         (int'(step_ff) < FRAME_DEPTH)) begin
                        tx_in[step_ff] = rumble_ff[i];
                        rumble_in[i]   = d;
                     end
                  end
               end
               default: begin
               end
            endcase

            // Send the frame byte at the current step.
            if (overrun) begin
               result.invalid_sequence = 1'b1;
               end_xfer                = 1'b1;
            end else begin
               result.reply_byte = (state_ff == ST_RUMBLE && rumble_hit) ? rumble_rd : tx_rd;
               result.button_pressed_seen = (state_ff == ST_POLL) &&
                  (step_ff == STEP_W'(ARG_STEP) || step_ff == STEP_W'(LOCK_STEP)) &&
                  (tx_rd != OPEN_BUS);
               result.acknowledge = !wrap;
               step_in = step_inc[STEP_W-1:0];
               if (wrap) begin
                  if (state_ff == ST_POLL) begin
                     result.poll_done          = 1'b1;
                     result.polled_button_bits = item.buttons;
                  end
                  end_xfer = 1'b1;
               end
            end
         end
      end

      if (end_xfer) begin
         state_in = ST_IDLE;
         step_in  = '0;
         long_in  = 1'b0;
         arg_in   = 1'b0;
         tx_in    = '{default: '0};
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff  <= ST_IDLE;
         step_ff   <= '0;
         long_ff   <= 1'b0;
         arg_ff    <= 1'b0;
         analog_ff <= 1'b0;
         config_ff <= 1'b0;
         lock_ff   <= 1'b0;
         tx_ff     <= '{default: '0};
         rumble_ff <= '{default: OPEN_BUS};
      end else if (fire) begin
         state_ff  <= state_in;
         step_ff   <= step_in;
         long_ff   <= long_in;
         arg_ff    <= arg_in;
         analog_ff <= analog_in;
         config_ff <= config_in;
         lock_ff   <= lock_in;
         tx_ff     <= tx_in;
         rumble_ff <= rumble_in;
      end
   end

endmodule

`default_nettype wire

// ----- hw/rtl/gamepad_serial_responder.sv -----
// Top level of the game-pad serial responder: ingress stage, engine and result register.
// Path: a transaction accepted into the ingress register is decided by the engine as it
// moves into the result register, from which the host side can take it.
// Throughput: one transaction per cycle; the input register refills while the result
// register drains, and rsp_stall holds both stages only when both are full.
// Reset (synchronous): pipeline empty, command state idle, modes off, rumble map 0xFF.
`timescale 1ns / 1ps
`default_nettype none

module gamepad_serial_responder #(
   parameter int FRAME_DEPTH  = 8,
   parameter int RUMBLE_DEPTH = 6
) (
   input  wire logic        clock,
   input  wire logic        reset,

   input  wire logic        req_valid,
   output logic             req_stall,
   input  wire logic        req_kind,
   input  wire logic [7:0]  req_host_byte,
   input  wire logic [15:0] req_buttons,
   input  wire logic [7:0]  req_left_x,
   input  wire logic [7:0]  req_left_y,
   input  wire logic [7:0]  req_right_x,
   input  wire logic [7:0]  req_right_y,

   output logic             rsp_valid,
   input  wire logic        rsp_stall,
   output logic [7:0]       rsp_reply_byte,
   output logic             rsp_acknowledge,
   output logic             rsp_invalid_sequence,
   output logic             rsp_saw_ident,
   output logic             rsp_saw_poll,
   output logic             rsp_button_pressed_seen,
   output logic             rsp_poll_done,
   output logic [15:0]      rsp_polled_button_bits
);
   import gsr_pkg::*;

   item_type   req_item;
   item_type   item;
   logic       item_valid;
   logic       take;
   result_type result;
   result_type result_ff;
   logic       rsp_valid_ff;
   logic       rsp_valid_in;

   assign req_item.kind      = req_kind;
   assign req_item.host_byte = req_host_byte;
   assign req_item.buttons   = req_buttons;
   assign req_item.left_x    = req_left_x;
   assign req_item.left_y    = req_left_y;
   assign req_item.right_x   = req_right_x;
   assign req_item.right_y   = req_right_y;

   // The held transaction moves into the result register whenever that register is
   // empty or is handing its transaction over in this same cycle.
   assign take = item_valid && (!rsp_valid_ff || !rsp_stall);

   gsr_ingress u_ingress (
      .clock      (clock),
      .reset      (reset),
      .req_valid  (req_valid),
      .req_stall  (req_stall),
      .req_item   (req_item),
      .take       (take),
      .item_valid (item_valid),
      .item       (item)
   );

   // All per-byte state lives in the engine and advances only on take.
   gsr_engine #(
      .FRAME_DEPTH  (FRAME_DEPTH),
      .RUMBLE_DEPTH (RUMBLE_DEPTH)
   ) u_engine (
      .clock  (clock),
      .reset  (reset),
      .fire   (take),
      .item   (item),
      .result (result)
   );

   // The result register stays full while the host side stalls it.
   assign rsp_valid_in = take || (rsp_valid_ff && rsp_stall);

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else begin
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (take) begin
         result_ff <= result;
      end
   end

   assign rsp_valid               = rsp_valid_ff;
   assign rsp_reply_byte          = result_ff.reply_byte;
   assign rsp_acknowledge         = result_ff.acknowledge;
   assign rsp_invalid_sequence    = result_ff.invalid_sequence;
   assign rsp_saw_ident           = result_ff.saw_ident;
   assign rsp_saw_poll            = result_ff.saw_poll;
   assign rsp_button_pressed_seen = result_ff.button_pressed_seen;
   assign rsp_poll_done           = result_ff.poll_done;
   assign rsp_polled_button_bits  = result_ff.polled_button_bits;

endmodule

`default_nettype wire

// ----- hw/rtl/gsr_checker.sv -----
// Port-level checks on the responder and the bind that attaches them.
`timescale 1ns / 1ps
`default_nettype none

module gsr_checker (
   input wire logic        clock,
   input wire logic        reset,
   input wire logic        rsp_valid,
   input wire logic        rsp_stall,
   input wire logic [7:0]  rsp_reply_byte,
   input wire logic        rsp_acknowledge,
   input wire logic        rsp_invalid_sequence,
   input wire logic        rsp_saw_ident,
   input wire logic        rsp_saw_poll,
   input wire logic        rsp_poll_done,
   input wire logic [15:0] rsp_polled_button_bits
);

   // A stalled result transaction stays offered and unchanged.
   assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_stall |=> rsp_valid && $stable(rsp_reply_byte)
         && $stable(rsp_acknowledge) && $stable(rsp_polled_button_bits))
      else $error("stalled result transaction changed");

   // The result side is empty in the cycle after reset.
   assert property (@(posedge clock) $past(reset) |-> !rsp_valid)
      else $error("result offered right after reset");

   // Button bits are reported only on the byte that finishes a poll.
   assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_poll_done |-> rsp_polled_button_bits == 16'h0000)
      else $error("button bits reported outside poll finish");

   // The pad never acknowledges a byte that it flags as invalid.
   assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_acknowledge |-> !rsp_invalid_sequence)
      else $error("acknowledge together with invalid sequence");

   // A poll command is also a recognized command, and it always expects more bytes.
   assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_saw_poll |-> rsp_saw_ident && rsp_acknowledge)
      else $error("poll command without ident or acknowledge");

endmodule

bind gamepad_serial_responder gsr_checker u_checker (
   .clock                  (clock),
   .reset                  (reset),
   .rsp_valid              (rsp_valid),
   .rsp_stall              (rsp_stall),
   .rsp_reply_byte         (rsp_reply_byte),
   .rsp_acknowledge        (rsp_acknowledge),
   .rsp_invalid_sequence   (rsp_invalid_sequence),
   .rsp_saw_ident          (rsp_saw_ident),
   .rsp_saw_poll           (rsp_saw_poll),
   .rsp_poll_done          (rsp_poll_done),
   .rsp_polled_button_bits (rsp_polled_button_bits)
);

`default_nettype wire

// ----- sim/tb.sv -----
// Self-checking testbench for the game-pad serial responder with its own reply predictor.
`timescale 1ns / 1ps

module tb;
   import gsr_pkg::*;

   // Cycles without any transaction on either channel before the run is declared hung.
   localparam int QUIET_LIMIT  = 2000;
   localparam int RUMBLE_SLOTS = 6;
   localparam int DRAIN_CYCLES = 10;

   // The pad's behavior, tracked one host byte at a time. Every accepted input
   // transaction yields exactly one expected reply, queued in arrival order.
   class pad_responder_board;
      cmd_state_type state;
      logic [2:0]    step;
      logic [3:0]    frame_len;
      logic [7:0]    rx_bytes [FRAME_BYTES];
      logic [7:0]    tx_bytes [FRAME_BYTES];
      logic [7:0]    rumble_bytes [RUMBLE_SLOTS];
      bit            analog_on;
      bit            config_on;
      bit            analog_lock;
      result_type    pending_replies [$];
      int            errors;

      function new();
         analog_on   = 1'b0;
         config_on   = 1'b0;
         analog_lock = 1'b0;
         errors      = 0;
         foreach (rumble_bytes[i]) rumble_bytes[i] = OPEN_BUS;
         clear_transfer();
      endfunction

      function void clear_transfer();
         state     = ST_IDLE;
         step      = '0;
         frame_len = '0;
         foreach (rx_bytes[i]) rx_bytes[i] = '0;
         foreach (tx_bytes[i]) tx_bytes[i] = '0;
      endfunction

      // Analog or config mode switches the pad to the long eight-byte frame.
      function bit long_frame();
         return config_on || analog_on;
      endfunction

      function logic [7:0] id_byte();
         logic [3:0] mode;
         if (config_on)
            mode = MODE_CONFIG;
         else if (analog_on)
            mode = MODE_ANALOG;
         else
            mode = MODE_DIGITAL;
         return long_frame() ? {mode, WORDS_LONG} : {mode, WORDS_SHORT};
      endfunction

      function void fill_frame(logic [7:0] b2, logic [7:0] b3, logic [7:0] b4,
                               logic [7:0] b5, logic [7:0] b6, logic [7:0] b7);
         tx_bytes[0] = id_byte();
         tx_bytes[1] = STATUS_BYTE;
         tx_bytes[2] = b2;
         tx_bytes[3] = b3;
         tx_bytes[4] = b4;
         tx_bytes[5] = b5;
         tx_bytes[6] = b6;
         tx_bytes[7] = b7;
      endfunction

      // Buttons low byte first; the long frame adds right stick then left stick.
      function void load_button_frame(item_type it);
         if (long_frame())
            fill_frame(it.buttons[7:0], it.buttons[15:8], it.right_x, it.right_y,
                       it.left_x, it.left_y);
         else
            fill_frame(it.buttons[7:0], it.buttons[15:8], 8'h00, 8'h00, 8'h00, 8'h00);
      endfunction

      function void take_host_byte(item_type it);
         result_type  r;
         bit          answers;
         int          step_after;
         logic [7:0]  d;
         logic [7:0]  arg;
         int          slot;
         r                  = '0;
         r.reply_byte       = OPEN_BUS;
         answers            = 1'b1;
         d                  = it.host_byte;
         if (it.kind) begin
            clear_transfer();
            answers = 1'b0;
         end else begin
            rx_bytes[step] = d;
            case (state)
               ST_IDLE: begin
                  if (d == START_BYTE) begin
                     state         = ST_READY;
                     r.acknowledge = 1'b1;
                  end else if (d != OPEN_BUS) begin
                     r.invalid_sequence = 1'b1;
                  end
                  answers = 1'b0;
               end
               ST_READY: begin
                  // The frame length is frozen here, from the modes in force now.
                  step        = '0;
                  frame_len   = long_frame() ? 4'd8 : 4'd4;
                  r.saw_ident = 1'b1;
                  if (d == CMD_POLL) begin
                     state      = ST_POLL;
                     load_button_frame(it);
                     r.saw_poll = 1'b1;
                  end else if (d == CMD_CONFIG) begin
                     state = ST_CFG;
                     if (!config_on)
                        load_button_frame(it);
                     else
                        fill_frame(8'h00, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00);
                  end else if (config_on && d == CMD_SET_ANALOG) begin
                     state = ST_SETANA;
                     fill_frame(8'h00, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00);
                     foreach (rumble_bytes[i]) rumble_bytes[i] = OPEN_BUS;
                  end else if (config_on && d == CMD_GET_ANALOG) begin
                     state = ST_GETANA;
                     fill_frame(8'h01, 8'h02, analog_on ? 8'h01 : 8'h00, 8'h02, 8'h01, 8'h00);
                  end else if (config_on && d == CMD_QUERY_46) begin
                     state = ST_Q46;
                     fill_frame(8'h00, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00);
                  end else if (config_on && d == CMD_QUERY_47) begin
                     state = ST_Q47;
                     fill_frame(8'h00, 8'h00, 8'h02, 8'h00, 8'h01, 8'h00);
                  end else if (config_on && d == CMD_QUERY_4C) begin
                     state = ST_Q4C;
                     fill_frame(8'h00, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00);
                  end else if (config_on && d == CMD_RUMBLE) begin
                     state = ST_RUMBLE;
                     fill_frame(8'h00, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00);
                  end else begin
                     // Unknown command: stay waiting for a command byte.
                     r.saw_ident        = 1'b0;
                     r.invalid_sequence = (d != OPEN_BUS);
                     answers            = 1'b0;
                  end
               end
               ST_CFG: begin
                  if (int'(step) == int'(frame_len) - 1)
                     config_on = (rx_bytes[ARG_STEP] == ARG_ON);
               end
               ST_SETANA: begin
                  if (step == ARG_STEP) begin
                     arg = rx_bytes[ARG_STEP];
                     if (arg == ARG_OFF || arg == ARG_ON)
                        analog_on = (arg == ARG_ON);
                  end else if (step == LOCK_STEP) begin
                     arg = rx_bytes[LOCK_STEP];
                     if (arg == LOCK_OFF || arg == LOCK_ON)
                        analog_lock = (arg == LOCK_ON);
                  end
               end
               ST_Q46: begin
                  // Two fixed answer tables, chosen by the argument byte.
                  if (step == ARG_STEP) begin
                     if (d == ARG_OFF) begin
                        tx_bytes[4] = 8'h01; tx_bytes[5] = 8'h02;
                        tx_bytes[6] = 8'h00; tx_bytes[7] = 8'h0A;
                     end else if (d == ARG_ON) begin
                        tx_bytes[4] = 8'h01; tx_bytes[5] = 8'h01;
                        tx_bytes[6] = 8'h01; tx_bytes[7] = 8'h14;
                     end
                  end
               end
               ST_Q47: begin
                  if (step == ARG_STEP && d != ARG_OFF) begin
                     tx_bytes[4] = 8'h00; tx_bytes[5] = 8'h00;
                     tx_bytes[6] = 8'h00; tx_bytes[7] = 8'h00;
                  end
               end
               ST_Q4C: begin
                  if (step == ARG_STEP) begin
                     if (d == ARG_OFF)
                        tx_bytes[5] = 8'h04;
                     else if (d == ARG_ON)
                        tx_bytes[5] = 8'h07;
                  end
               end
               ST_RUMBLE: begin
                  // Each slot answers its old mapping and takes the host byte.
                  if (step >= RUMBLE_FIRST_STEP && step <= RUMBLE_LAST_STEP) begin
                     slot = int'(step) - RUMBLE_FIRST_STEP;
                     if (slot < RUMBLE_SLOTS) begin
                        tx_bytes[step]     = rumble_bytes[slot];
                        rumble_bytes[slot] = d;
                     end
                  end
               end
               default: ;
            endcase
         end

         if (answers) begin
            if (frame_len == 0) begin
               r.invalid_sequence = 1'b1;
               clear_transfer();
            end else begin
               if (state == ST_POLL && (step == ARG_STEP || step == LOCK_STEP) &&
                   tx_bytes[step] != OPEN_BUS)
                  r.button_pressed_seen = 1'b1;
               r.reply_byte  = tx_bytes[step];
               step_after    = (int'(step) + 1) % int'(frame_len);
               step          = step_after[2:0];
               r.acknowledge = (step_after != 0);
               if (step_after == 0) begin
                  if (state == ST_POLL) begin
                     r.poll_done          = 1'b1;
                     r.polled_button_bits = it.buttons;
                  end
                  clear_transfer();
               end
            end
         end
         pending_replies.push_back(r);
      endfunction

      function void compare_field(string field, int unsigned want, int unsigned seen);
         if (want != seen) begin
            errors++;
            $display("%0t: %s mismatch, expected 0x%0h, actual 0x%0h", $time, field, want, seen);
         end
      endfunction

      function void check_reply(result_type got);
         result_type want;
         if (pending_replies.size() == 0) begin
            errors++;
            $display("%0t: reply with none outstanding, expected nothing, actual 0x%0h",
                     $time, got);
         end else begin
            want = pending_replies.pop_front();
            compare_field("reply_byte", want.reply_byte, got.reply_byte);
            compare_field("acknowledge", want.acknowledge, got.acknowledge);
            compare_field("invalid_sequence", want.invalid_sequence, got.invalid_sequence);
            compare_field("saw_ident", want.saw_ident, got.saw_ident);
            compare_field("saw_poll", want.saw_poll, got.saw_poll);
            compare_field("button_pressed_seen", want.button_pressed_seen,
                          got.button_pressed_seen);
            compare_field("poll_done", want.poll_done, got.poll_done);
            compare_field("polled_button_bits", want.polled_button_bits,
                          got.polled_button_bits);
         end
      endfunction
   endclass

   logic        clock;
   logic        reset;
   logic        req_valid;
   logic        req_stall;
   logic        req_kind;
   logic [7:0]  req_host_byte;
   logic [15:0] req_buttons;
   logic [7:0]  req_left_x;
   logic [7:0]  req_left_y;
   logic [7:0]  req_right_x;
   logic [7:0]  req_right_y;
   logic        rsp_valid;
   logic        rsp_stall;
   logic [7:0]  rsp_reply_byte;
   logic        rsp_acknowledge;
   logic        rsp_invalid_sequence;
   logic        rsp_saw_ident;
   logic        rsp_saw_poll;
   logic        rsp_button_pressed_seen;
   logic        rsp_poll_done;
   logic [15:0] rsp_polled_button_bits;

   pad_responder_board board;
   int send_pct;
   int recv_pct;
   int items_sent;

   // Commands the pad honors while in config mode.
   logic [7:0] config_cmds [8] = '{CMD_POLL, CMD_CONFIG, CMD_SET_ANALOG, CMD_GET_ANALOG,
                                   CMD_QUERY_46, CMD_QUERY_47, CMD_QUERY_4C, CMD_RUMBLE};

   wire req_taken = req_valid && !req_stall;
   wire rsp_taken = rsp_valid && !rsp_stall;

   gamepad_serial_responder uut (
      .clock                  (clock),
      .reset                  (reset),
      .req_valid              (req_valid),
      .req_stall              (req_stall),
      .req_kind               (req_kind),
      .req_host_byte          (req_host_byte),
      .req_buttons            (req_buttons),
      .req_left_x             (req_left_x),
      .req_left_y             (req_left_y),
      .req_right_x            (req_right_x),
      .req_right_y            (req_right_y),
      .rsp_valid              (rsp_valid),
      .rsp_stall              (rsp_stall),
      .rsp_reply_byte         (rsp_reply_byte),
      .rsp_acknowledge        (rsp_acknowledge),
      .rsp_invalid_sequence   (rsp_invalid_sequence),
      .rsp_saw_ident          (rsp_saw_ident),
      .rsp_saw_poll           (rsp_saw_poll),
      .rsp_button_pressed_seen(rsp_button_pressed_seen),
      .rsp_poll_done          (rsp_poll_done),
      .rsp_polled_button_bits (rsp_polled_button_bits)
   );

   initial begin
      clock = 1'b0;
      forever #5 clock = ~clock;
   end

   // The host side stalls replies at random, at the rate of the current phase.
   always @(negedge clock) begin
      rsp_stall <= ($urandom_range(99) < recv_pct);
   end

   // Every reply the host takes is checked against the oldest prediction.
   always @(posedge clock) begin : reply_monitor
      result_type got;
      if (!reset && rsp_taken) begin
         got.reply_byte          = rsp_reply_byte;
         got.acknowledge         = rsp_acknowledge;
         got.invalid_sequence    = rsp_invalid_sequence;
         got.saw_ident           = rsp_saw_ident;
         got.saw_poll            = rsp_saw_poll;
         got.button_pressed_seen = rsp_button_pressed_seen;
         got.poll_done           = rsp_poll_done;
         got.polled_button_bits  = rsp_polled_button_bits;
         board.check_reply(got);
      end
   end

   // A run in which neither channel moves for too long is treated as hung.
   initial begin : watchdog
      int quiet;
      quiet = 0;
      while (quiet < QUIET_LIMIT) begin
         @(posedge clock);
         if (reset || req_taken || rsp_taken)
            quiet = 0;
         else
            quiet++;
      end
      $display("TB_ERROR");
      $finish;
   end

   // Offers one transaction, possibly after a random gap, and holds it until taken.
   // Entered and left at a falling edge, so valid is never assigned twice in one step.
   task automatic push_item(input item_type it);
      while ($urandom_range(99) < send_pct) begin
         req_valid <= 1'b0;
         @(negedge clock);
      end
      req_valid     <= 1'b1;
      req_kind      <= it.kind;
      req_host_byte <= it.host_byte;
      req_buttons   <= it.buttons;
      req_left_x    <= it.left_x;
      req_left_y    <= it.left_y;
      req_right_x   <= it.right_x;
      req_right_y   <= it.right_y;
      do @(posedge clock); while (req_stall);
      board.take_host_byte(it);
      items_sent++;
      @(negedge clock);
   endtask

   function automatic logic [15:0] random_buttons();
      case ($urandom_range(3))
         0:       return 16'hFFFF;
         1:       return {8'hFF, 8'($urandom_range(255))};
         default: return 16'($urandom_range(65535));
      endcase
   endfunction

   function automatic item_type pad_item(logic [7:0] host, logic [15:0] btn, logic [7:0] stick);
      item_type it;
      it.kind      = 1'b0;
      it.host_byte = host;
      it.buttons   = btn;
      it.left_x    = stick;
      it.left_y    = stick;
      it.right_x   = stick;
      it.right_y   = stick;
      return it;
   endfunction

   task automatic send_byte(input logic [7:0] host);
      item_type it;
      it.kind      = 1'b0;
      it.host_byte = host;
      it.buttons   = random_buttons();
      it.left_x    = 8'($urandom_range(255));
      it.left_y    = 8'($urandom_range(255));
      it.right_x   = 8'($urandom_range(255));
      it.right_y   = 8'($urandom_range(255));
      push_item(it);
   endtask

   // Select released: the host byte carried along must not matter.
   task automatic send_abort();
      item_type it;
      it      = pad_item(8'($urandom_range(255)), random_buttons(), 8'($urandom_range(255)));
      it.kind = 1'b1;
      push_item(it);
   endtask

   // Argument bytes lean on the values the commands decode.
   function automatic logic [7:0] pick_arg();
      case ($urandom_range(5))
         0:       return ARG_OFF;
         1:       return ARG_ON;
         2:       return LOCK_OFF;
         3:       return LOCK_ON;
         4:       return OPEN_BUS;
         default: return 8'($urandom_range(255));
      endcase
   endfunction

   // One full transfer: start byte, command, then the rest of the frame. Now and
   // then the host drops select part way through.
   task automatic random_transfer();
      logic [7:0] cmd;
      logic [7:0] host;
      int         len;
      int         cut;
      if ($urandom_range(99) < 5)
         cmd = 8'($urandom_range(255));
      else if (board.config_on)
         cmd = config_cmds[$urandom_range(7)];
      else
         cmd = ($urandom_range(99) < 60) ? CMD_POLL : CMD_CONFIG;
      len = board.long_frame() ? 8 : 4;
      cut = ($urandom_range(99) < 8) ? int'($urandom_range(len)) : -1;
      send_byte(START_BYTE);
      for (int s = 0; s < len; s++) begin
         if (s == cut) begin
            send_abort();
            return;
         end
         if (s == 0)
            host = cmd;
         else if (s == ARG_STEP)
            host = $urandom_range(1) ? ARG_ON : pick_arg();
         else if (s == LOCK_STEP)
            host = pick_arg();
         else
            host = 8'($urandom_range(255));
         send_byte(host);
      end
   endtask

   // Holds the sender off until the pad has answered everything sent so far.
   task automatic drain_replies();
      req_valid <= 1'b0;
      do @(negedge clock); while (board.pending_replies.size() != 0);
   endtask

   task automatic random_until(input int target);
      int pick;
      while (items_sent < target) begin
         pick = $urandom_range(99);
         if (pick < 75) begin
            random_transfer();
         end else if (pick < 85) begin
            send_byte(8'($urandom_range(255)));
         end else if (pick < 92) begin
            send_abort();
         end else if (pick < 98) begin
            // Start byte followed by junk in place of a command.
            send_byte(START_BYTE);
            send_byte(8'($urandom_range(255)));
         end else begin
            drain_replies();
         end
      end
   endtask

   initial begin
      board         = new();
      items_sent    = 0;
      send_pct      = 34;
      recv_pct      = 60;
      reset         = 1'b1;
      req_valid     = 1'b0;
      rsp_stall     = 1'b0;
      req_kind      = 1'b0;
      req_host_byte = '0;
      req_buttons   = '0;
      req_left_x    = '0;
      req_left_y    = '0;
      req_right_x   = '0;
      req_right_y   = '0;
      repeat (7) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;

      // Directed opening: idle bytes, an abort, polls with every button down and
      // every button up, entering config mode, and an unknown command in config mode.
      send_byte(OPEN_BUS);
      send_byte(8'h00);
      send_abort();
      push_item(pad_item(START_BYTE, 16'h0000, 8'h00));
      push_item(pad_item(CMD_POLL, 16'h0000, 8'h00));
      push_item(pad_item(8'h00, 16'h0000, 8'h00));
      push_item(pad_item(8'h00, 16'h0000, 8'h00));
      push_item(pad_item(START_BYTE, 16'hFFFF, 8'hFF));
      push_item(pad_item(CMD_POLL, 16'hFFFF, 8'hFF));
      push_item(pad_item(OPEN_BUS, 16'hFFFF, 8'hFF));
      push_item(pad_item(OPEN_BUS, 16'hFFFF, 8'hFF));
      send_byte(START_BYTE);
      send_byte(CMD_CONFIG);
      send_byte(8'h00);
      send_byte(ARG_ON);
      send_byte(8'h00);
      send_byte(START_BYTE);
      send_byte(8'h50);
      send_byte(OPEN_BUS);
      send_abort();

      // Three phases: sender busy and host slow, the reverse, then full speed.
      random_until(650);
      drain_replies();
      send_pct = 60;
      recv_pct = 34;
      random_until(1300);
      drain_replies();
      send_pct = 0;
      recv_pct = 0;
      random_until(1900);
      req_valid <= 1'b0;

      while (board.pending_replies.size() != 0) @(posedge clock);
      repeat (DRAIN_CYCLES) @(posedge clock);
      if (board.errors == 0)
         $display("TB_OK");
      else
         $display("TB_ERROR");
      $finish;
   end

endmodule
